@@ src/sieve_prime_factorizer_assert.svh @@
// assertion macros for the sieve prime factorizer
// expects a clock i_clk and an active-low reset i_rst_n in the including scope
`ifndef SIEVE_PRIME_FACTORIZER_ASSERT_SVH
`define SIEVE_PRIME_FACTORIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/spf_pkg.sv @@
// shared types and constants of the sieve prime factorizer
// no dependencies
package spf_pkg;

    // store geometry
    localparam int SIEVE_ENTRIES = 65536;
    localparam int IDX_W         = $clog2(SIEVE_ENTRIES);

    // field widths
    localparam int LIM_W   = 17;
    localparam int PRIME_W = 17;
    localparam int EXP_W   = 4;
    localparam int MUL_W   = 8;
    localparam int POW_W   = 12;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 3;

    // sieve counter widths: odd candidate, its square, and the marking walk
    localparam int I_W  = LIM_W + 1;
    localparam int SQ_W = 2 * I_W;
    localparam int J_W  = LIM_W + 2;

    // limit bounds applied at build start, reset limit and per-query pair bound
    localparam int LIM_CAP       = 2 * SIEVE_ENTRIES - 1;
    localparam int LIM_MIN       = 3;
    localparam int LIM_RESET     = 131071;
    localparam int MAX_PAIRS     = 5;

    // opcodes
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] ST_PAIR  = 2'd0;
    localparam logic [ST_W-1:0] ST_BUILT = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd2;
    localparam logic [ST_W-1:0] ST_ERR   = 2'd3;

    // one store entry: smallest prime, its exponent, index of odd cofactor
    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic [EXP_W-1:0]   exp;
        logic [IDX_W-1:0]   next;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_OUTER_RD,
        S_OUTER_CHK,
        S_INNER_RD,
        S_INNER_CHK,
        S_INNER_PREV,
        S_RESP,
        S_QUERY_RD,
        S_QUERY_CHK
    } t_state;

endpackage

@@ src/sieve_prime_factorizer.sv @@
// sieve prime factorizer top level: sequencer, sieve store and result register
// depends on spf_pkg and sieve_prime_factorizer_assert.svh

// Odd-only smallest-prime-factor sieve held in a 65536 x 37 bit synchronous
// RAM (one access per cycle, registered read data). A build (opcode 0)
// first clears entries 0 to limit/2, one per cycle, then walks the odd
// candidates (read, then check and mark a new prime). For each prime p with
// p*p not above the limit it walks the odd multiples from p*p, reading each
// and, for one not yet marked, reading the cofactor entry and writing the
// target, then leaves that walk. The build ends with one status-1 result. A
// query (opcode 1) reads one store entry per (prime, power) pair, at most
// five pairs, the last flagged, and returns to idle before the next item.
// Value 1, even, too large or unbuilt queries give a single result through
// the response state, and the next item can follow once the sequencer is
// back in idle. A stalled output register holds the sequencer until it
// drains. A new item is taken once the previous item's last result sits in
// the output register. The limit register is read at build start and
// clamped to the range 3 to 131071.
module sieve_prime_factorizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [spf_pkg::LIM_W-1:0]   i_cfg_sieve_limit,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [spf_pkg::LIM_W-1:0]   i_query_value,
    input  logic [spf_pkg::MUL_W-1:0]   i_exponent_multiplier,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [spf_pkg::ST_W-1:0]    o_status,
    output logic [spf_pkg::PRIME_W-1:0] o_prime,
    output logic [spf_pkg::POW_W-1:0]   o_power,
    output logic                        o_last
);

    localparam int LIM_W   = spf_pkg::LIM_W;
    localparam int IDX_W   = spf_pkg::IDX_W;
    localparam int PRIME_W = spf_pkg::PRIME_W;
    localparam int EXP_W   = spf_pkg::EXP_W;
    localparam int MUL_W   = spf_pkg::MUL_W;
    localparam int POW_W   = spf_pkg::POW_W;
    localparam int ST_W    = spf_pkg::ST_W;
    localparam int CNT_W   = spf_pkg::CNT_W;
    localparam int I_W     = spf_pkg::I_W;
    localparam int SQ_W    = spf_pkg::SQ_W;
    localparam int J_W     = spf_pkg::J_W;

    // control and datapath registers
    spf_pkg::t_state        r_state, n_state;
    logic [LIM_W-1:0]       r_sieve_limit;
    logic                   r_built, n_built;
    logic [LIM_W-1:0]       r_built_limit, n_built_limit;
    logic [LIM_W-1:0]       r_lim, n_lim;
    logic [IDX_W-1:0]       r_addr, n_addr;
    logic [I_W-1:0]         r_i, n_i;
    logic [SQ_W-1:0]        r_sq, n_sq;
    logic [J_W-1:0]         r_j, n_j;
    logic [IDX_W-1:0]       r_k, n_k;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [MUL_W-1:0]       r_mul, n_mul;
    logic [ST_W-1:0]        r_resp, n_resp;

    // result register
    logic                   r_out_valid;
    logic [ST_W-1:0]        r_status;
    logic [PRIME_W-1:0]     r_prime;
    logic [POW_W-1:0]       r_power;
    logic                   r_last;

    // store and its ports
    spf_pkg::t_entry        r_sieve_store [spf_pkg::SIEVE_ENTRIES];
    spf_pkg::t_entry        r_rdata;
    logic                   w_rd_en;
    logic [IDX_W-1:0]       w_rd_addr;
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_wr_addr;
    spf_pkg::t_entry        w_wr_data;

    // result load controls
    logic                   w_out_load;
    logic [ST_W-1:0]        w_out_status;
    logic [PRIME_W-1:0]     w_out_prime;
    logic [POW_W-1:0]       w_out_power;
    logic                   w_out_last;

    // handshake and decode helpers
    logic                   w_in_fire;
    logic                   w_out_free;
    logic                   w_query_err;
    logic                   w_q_last;
    logic                   w_i_over;
    logic                   w_sq_over;
    logic                   w_j_over;
    logic                   w_clear_end;
    logic [LIM_W-1:0]       w_lim_clamped;
    logic [I_W-1:0]         w_i_next;
    logic [SQ_W-1:0]        w_sq_next;
    logic [J_W-1:0]         w_j_next;

    assign o_in_ready  = i_rst_n && (r_state == spf_pkg::S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // limit clamp taken at build start
    always_comb begin
        w_lim_clamped = r_sieve_limit;
        if (32'(r_sieve_limit) > spf_pkg::LIM_CAP) begin
            w_lim_clamped = LIM_W'(spf_pkg::LIM_CAP);
        end
        if (32'(r_sieve_limit) < spf_pkg::LIM_MIN) begin
            w_lim_clamped = LIM_W'(spf_pkg::LIM_MIN);
        end
    end

    // query checks and sieve loop bounds
    assign w_query_err = !r_built || !i_query_value[0] || (i_query_value > r_built_limit);
    assign w_q_last    = (r_rdata.next == '0) ||
                         (r_cnt == CNT_W'(spf_pkg::MAX_PAIRS - 1));
    assign w_i_over    = r_i > I_W'(r_lim);
    assign w_sq_over   = r_sq > SQ_W'(r_lim);
    assign w_j_over    = r_j > J_W'(r_lim);
    assign w_clear_end = r_addr == r_lim[IDX_W:1];
    // (i+2)^2 = i^2 + 4i + 4
    assign w_i_next    = r_i + I_W'(2);
    assign w_sq_next   = r_sq + SQ_W'({r_i, 2'b00}) + SQ_W'(4);
    assign w_j_next    = r_j + J_W'({r_i, 1'b0});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spf_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    if (i_opcode == spf_pkg::OP_BUILD) begin
                        n_state = spf_pkg::S_CLEAR;
                    end else if (w_query_err || (i_query_value[LIM_W-1:1] == '0)) begin
                        n_state = spf_pkg::S_RESP;
                    end else begin
                        n_state = spf_pkg::S_QUERY_RD;
                    end
                end
            end
            spf_pkg::S_CLEAR: begin
                if (w_clear_end) begin
                    n_state = spf_pkg::S_OUTER_RD;
                end
            end
            spf_pkg::S_OUTER_RD: begin
                n_state = w_i_over ? spf_pkg::S_RESP : spf_pkg::S_OUTER_CHK;
            end
            spf_pkg::S_OUTER_CHK: begin
                if ((r_rdata.prime != '0) || w_sq_over) begin
                    n_state = spf_pkg::S_OUTER_RD;
                end else begin
                    n_state = spf_pkg::S_INNER_RD;
                end
            end
            spf_pkg::S_INNER_RD: begin
                n_state = w_j_over ? spf_pkg::S_OUTER_RD : spf_pkg::S_INNER_CHK;
            end
            spf_pkg::S_INNER_CHK: begin
                n_state = (r_rdata.prime != '0) ? spf_pkg::S_INNER_RD : spf_pkg::S_INNER_PREV;
            end
            spf_pkg::S_INNER_PREV: begin
                n_state = spf_pkg::S_INNER_RD;
            end
            spf_pkg::S_RESP: begin
                if (w_out_free) begin
                    n_state = spf_pkg::S_IDLE;
                end
            end
            spf_pkg::S_QUERY_RD: begin
                n_state = spf_pkg::S_QUERY_CHK;
            end
            spf_pkg::S_QUERY_CHK: begin
                if (w_out_free) begin
                    n_state = w_q_last ? spf_pkg::S_IDLE : spf_pkg::S_QUERY_RD;
                end
            end
            default: begin
                n_state = spf_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, store access and result load per state
    always_comb begin
        n_built       = r_built;
        n_built_limit = r_built_limit;
        n_lim         = r_lim;
        n_addr        = r_addr;
        n_i           = r_i;
        n_sq          = r_sq;
        n_j           = r_j;
        n_k           = r_k;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        n_mul         = r_mul;
        n_resp        = r_resp;
        w_rd_en       = 1'b0;
        w_rd_addr     = r_idx;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_addr;
        w_wr_data     = '0;
        w_out_load    = 1'b0;
        w_out_status  = r_resp;
        w_out_prime   = '0;
        w_out_power   = '0;
        w_out_last    = 1'b1;
        unique case (r_state)
            spf_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_lim  = w_lim_clamped;
                    n_addr = '0;
                    n_idx  = i_query_value[IDX_W:1];
                    n_cnt  = '0;
                    n_mul  = i_exponent_multiplier;
                    n_resp = w_query_err ? spf_pkg::ST_ERR : spf_pkg::ST_NONE;
                end
            end
            spf_pkg::S_CLEAR: begin
                // entry 0 stands for the number one
                w_wr_en   = 1'b1;
                w_wr_addr = r_addr;
                if (r_addr == '0) begin
                    w_wr_data.prime = PRIME_W'(1);
                    w_wr_data.exp   = EXP_W'(1);
                end
                n_addr = r_addr + IDX_W'(1);
                n_i    = I_W'(3);
                n_sq   = SQ_W'(9);
            end
            spf_pkg::S_OUTER_RD: begin
                if (w_i_over) begin
                    n_built       = 1'b1;
                    n_built_limit = r_lim;
                    n_resp        = spf_pkg::ST_BUILT;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_i[IDX_W:1];
                end
            end
            spf_pkg::S_OUTER_CHK: begin
                // unmarked candidate is prime
                if (r_rdata.prime == '0) begin
                    w_wr_en         = 1'b1;
                    w_wr_addr       = r_i[IDX_W:1];
                    w_wr_data.prime = PRIME_W'(r_i);
                    w_wr_data.exp   = EXP_W'(1);
                end
                if ((r_rdata.prime != '0) || w_sq_over) begin
                    n_i  = w_i_next;
                    n_sq = w_sq_next;
                end else begin
                    n_j = J_W'(r_sq);
                    n_k = r_i[IDX_W:1];
                end
            end
            spf_pkg::S_INNER_RD: begin
                if (w_j_over) begin
                    n_i  = w_i_next;
                    n_sq = w_sq_next;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_j[IDX_W:1];
                end
            end
            spf_pkg::S_INNER_CHK: begin
                if (r_rdata.prime != '0) begin
                    n_j = w_j_next;
                    n_k = r_k + IDX_W'(1);
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_k;
                end
            end
            spf_pkg::S_INNER_PREV: begin
                // if cofactor j/p has p as smallest prime: bump exp, else exp 1
                w_wr_en         = 1'b1;
                w_wr_addr       = r_j[IDX_W:1];
                w_wr_data.prime = PRIME_W'(r_i);
                if (r_rdata.prime == PRIME_W'(r_i)) begin
                    w_wr_data.exp  = r_rdata.exp + EXP_W'(1);
                    w_wr_data.next = r_rdata.next;
                end else begin
                    w_wr_data.exp  = EXP_W'(1);
                    w_wr_data.next = r_k;
                end
                n_j = w_j_next;
                n_k = r_k + IDX_W'(1);
            end
            spf_pkg::S_RESP: begin
                w_out_load = w_out_free;
            end
            spf_pkg::S_QUERY_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx;
            end
            spf_pkg::S_QUERY_CHK: begin
                w_out_load   = w_out_free;
                w_out_status = spf_pkg::ST_PAIR;
                w_out_prime  = r_rdata.prime;
                w_out_power  = POW_W'(r_rdata.exp) * POW_W'(r_mul);
                w_out_last   = w_q_last;
                if (w_out_free) begin
                    n_idx = r_rdata.next;
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= spf_pkg::S_IDLE;
            r_sieve_limit <= LIM_W'(spf_pkg::LIM_RESET);
            r_built       <= 1'b0;
            r_built_limit <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_built       <= n_built;
            r_built_limit <= n_built_limit;
            if (i_cfg_valid && o_cfg_ready) begin
                r_sieve_limit <= i_cfg_sieve_limit;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_lim  <= n_lim;
        r_addr <= n_addr;
        r_i    <= n_i;
        r_sq   <= n_sq;
        r_j    <= n_j;
        r_k    <= n_k;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_mul  <= n_mul;
        r_resp <= n_resp;
        if (w_out_load) begin
            r_status <= w_out_status;
            r_prime  <= w_out_prime;
            r_power  <= w_out_power;
            r_last   <= w_out_last;
        end
    end

    // sieve store write port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_sieve_store[w_wr_addr] <= w_wr_data;
        end
    end

    // sieve store read port, registered data
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_sieve_store[w_rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_prime     = r_prime;
    assign o_power     = r_power;
    assign o_last      = r_last;

    `include "sieve_prime_factorizer_assert.svh"

    // store takes one access per cycle
    `SPF_ASSERT_NOW(a_one_access, w_rd_en, !w_wr_en, "store read and write in one cycle")
    // a chain walk only starts on a built store
    `SPF_ASSERT_NOW(a_walk_built, r_state == spf_pkg::S_QUERY_RD, r_built, "walk on unbuilt store")
    // never more than five pairs for one query
    `SPF_ASSERT_NOW(a_pair_bound, r_state == spf_pkg::S_QUERY_CHK,
        r_cnt < CNT_W'(spf_pkg::MAX_PAIRS), "query walk exceeds five pairs")
    // build done result only once the flag is set
    `SPF_ASSERT_NEXT(a_build_flag, w_out_load && (w_out_status == spf_pkg::ST_BUILT),
        r_built && (r_built_limit == $past(r_lim)), "build done without built flag")

endmodule
